// ===== rtl/sfd_pkg.sv =====
// ============================================================================
// sfd_pkg: shared types and constants for the frame deframer
// Result codes, frame geometry constants and the byte-wide CRC-16 update.
// ============================================================================
package sfd_pkg;

    localparam int unsigned POS_W = 9;               // byte position, saturates
    localparam logic [POS_W-1:0] POS_SAT   = 9'd256;
    localparam logic [POS_W-1:0] POS_OVR   = 9'd255; // beyond 255 bytes
    localparam logic [POS_W-1:0] MIN_SIZE  = 9'd5;
    localparam logic [POS_W-1:0] FRAME_OVH = 9'd4;
    localparam logic [7:0]       MAX_LEN   = 8'd251;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [1:0] {
        KIND_CMD     = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_STATUS  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SHORT = 2'd1,
        ST_LEN_ERR  = 2'd2,
        ST_CRC_ERR  = 2'd3
    } status_t;

    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] value;
        status_t    status;
    } result_t;

    // CRC-16/CCITT-FALSE, MSB first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/sfd_parser.sv =====
// ============================================================================
// sfd_parser: per-byte frame state and result decode
// Tracks position, length, running CRC and error flags; decodes one result.
// ============================================================================
module sfd_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          start_byte,
    input  logic                in_accept,
    input  logic [7:0]          data_byte,
    input  logic                end_of_buffer,
    output sfd_pkg::result_t    result
);

    logic [sfd_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [7:0]                len_reg, len_next;
    logic [15:0]               crc_reg, crc_next;
    logic [7:0]                rxh_reg, rxh_next;
    logic                      bad_reg, bad_next;
    logic                      ovr_reg, ovr_next;

    logic                      len_ok;
    logic [sfd_pkg::POS_W-1:0] len_p1, len_p2, len_p4, size;
    logic [15:0]               crc_upd;

    always_comb begin
        bad_next = (pos_reg == '0) ? (data_byte != start_byte) : bad_reg;
        len_next = (pos_reg == 9'd1) ? data_byte : len_reg;
        len_ok   = (len_next != 8'd0) && (len_next <= sfd_pkg::MAX_LEN);
        len_p1   = {1'b0, len_next} + 9'd1;
        len_p2   = {1'b0, len_next} + 9'd2;
        len_p4   = {1'b0, len_next} + sfd_pkg::FRAME_OVH;
        size     = pos_reg + 9'd1;

        crc_upd  = sfd_pkg::crc_byte(crc_reg, data_byte);
        crc_next = (pos_reg < 9'd2 || pos_reg < len_p2) ? crc_upd : crc_reg;
        rxh_next = (pos_reg >= 9'd2 && pos_reg == len_p2) ? data_byte : rxh_reg;
        ovr_next = ovr_reg || (pos_reg >= sfd_pkg::POS_OVR);
        pos_next = (pos_reg < sfd_pkg::POS_SAT) ? pos_reg + 9'd1 : pos_reg;

        result        = '0;
        result.kind   = sfd_pkg::KIND_CMD;
        result.status = sfd_pkg::ST_OK;
        if (end_of_buffer) begin
            result.valid = 1'b1;
            result.kind  = sfd_pkg::KIND_STATUS;
            if (size < sfd_pkg::MIN_SIZE || bad_next) begin
                result.status = sfd_pkg::ST_BAD_SHORT;
            end else if (!len_ok || ovr_next || size != len_p4) begin
                result.status = sfd_pkg::ST_LEN_ERR;
            end else if ({rxh_next, data_byte} == crc_next) begin
                result.status = sfd_pkg::ST_OK;
            end else begin
                result.status = sfd_pkg::ST_CRC_ERR;
            end
        end else if (!bad_next && len_ok && pos_reg >= 9'd2) begin
            if (pos_reg == 9'd2) begin
                result.valid = 1'b1;
                result.kind  = sfd_pkg::KIND_CMD;
                result.value = data_byte;
            end else if (pos_reg <= len_p1) begin
                result.valid = 1'b1;
                result.kind  = sfd_pkg::KIND_PAYLOAD;
                result.value = data_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (in_accept && end_of_buffer)) begin
            pos_reg <= '0;
            len_reg <= '0;
            crc_reg <= sfd_pkg::CRC_INIT;
            rxh_reg <= '0;
            bad_reg <= 1'b0;
            ovr_reg <= 1'b0;
        end else if (in_accept) begin
            pos_reg <= pos_next;
            len_reg <= len_next;
            crc_reg <= crc_next;
            rxh_reg <= rxh_next;
            bad_reg <= bad_next;
            ovr_reg <= ovr_next;
        end
    end

    // a buffer end always returns the frame state to its start
    a_clear_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && end_of_buffer |=> pos_reg == '0 && crc_reg == sfd_pkg::CRC_INIT)
        else $error("frame state not cleared after buffer end");

    a_pos_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= sfd_pkg::POS_SAT)
        else $error("byte position past saturation");

endmodule

// ===== rtl/serial_frame_deframer_crc16.sv =====
// ============================================================================
// serial_frame_deframer_crc16: length-prefixed frame parser, CRC-16 check
// Streams out command and payload bytes of a buffer and one status per buffer.
// ============================================================================
//
//  channel  dir  tdata (low bit up)          tuser   tlast
//  s_       in   [7:0] data_byte             -       end_of_buffer
//  m_       out  [7:0] value, [9:8] status   kind    -
//  cfg_     in   [7:0] start_byte (cfg_we)   -       -
//
// One byte per cycle while s_tready is high: each accepted transaction runs
// through the parser's frame registers and the byte-wide CRC update, and any
// result lands in the output register (or the skid register if m_tready is low) on that edge.
// A skid register behind the output register keeps s_tready independent of
// m_tready; input stalls only while the skid holds a result.
// Reset (aresetn low, synchronous) empties both result registers, clears the
// frame state and sets start_byte to zero.
//
module serial_frame_deframer_crc16 (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,     // start_byte
    // byte stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] data_byte
    input  logic        s_tlast,       // end_of_buffer
    // results out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,       // [7:0] value, [9:8] status, rest zero
    output logic [1:0]  m_tuser        // kind
);

    logic [7:0]        start_byte_reg;
    logic              in_accept;
    sfd_pkg::result_t  new_res;

    // output register and skid register
    sfd_pkg::result_t  out_reg, out_next;
    sfd_pkg::result_t  skid_reg, skid_next;
    logic              out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg <= '0;
        end else if (cfg_we) begin
            start_byte_reg <= cfg_wdata;
        end
    end

    assign s_tready  = !skid_reg.valid;
    assign in_accept = s_tvalid && s_tready;

    sfd_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start_byte    (start_byte_reg),
        .in_accept     (in_accept),
        .data_byte     (s_tdata),
        .end_of_buffer (s_tlast),
        .result        (new_res)
    );

    // output slot is free when empty or being taken this cycle
    assign out_load = !out_reg.valid || m_tready;

    always_comb begin
        out_next  = out_reg;
        skid_next = skid_reg;
        if (skid_reg.valid) begin
            // no input accepted; drain the skid first
            if (out_load) begin
                out_next       = skid_reg;
                skid_next.valid = 1'b0;
            end
        end else if (in_accept && new_res.valid) begin
            if (out_load) begin
                out_next = new_res;
            end else begin
                skid_next = new_res;
            end
        end else if (out_load) begin
            out_next.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg  <= '0;
            skid_reg <= '0;
        end else begin
            out_reg  <= out_next;
            skid_reg <= skid_next;
        end
    end

    assign m_tvalid = out_reg.valid;
    assign m_tdata  = {6'd0, out_reg.status, out_reg.value};
    assign m_tuser  = out_reg.kind;

    // skid only fills behind a stalled output
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_reg.valid |-> out_reg.valid)
        else $error("skid holds a result while output register is empty");

    a_status_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == sfd_pkg::KIND_STATUS |-> m_tdata[7:0] == 8'd0)
        else $error("status transaction with nonzero value");

    a_data_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != sfd_pkg::KIND_STATUS |-> m_tdata[9:8] == 2'd0)
        else $error("data transaction with nonzero status");

    a_last_gives_status: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && s_tlast |-> new_res.valid && new_res.kind == sfd_pkg::KIND_STATUS)
        else $error("buffer end without status result");

endmodule
